[rtl/jac_pkg.sv]
// ----------------------------------------------------------------------------
// jac_pkg
// shared types, constants and codes for the joystick axis conditioner
// ----------------------------------------------------------------------------
`default_nettype none

package jac_pkg;

    localparam int DEAD_ZONE     = 10;
    localparam int DIR_THRESHOLD = 50;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [8:0] ALPHA_ONE    = 9'd256;
    localparam logic [8:0] WEIGHT_RESET = 9'd77;

    // configuration register indexes
    localparam logic CFG_LOWPASS_ON    = 1'b0;
    localparam logic CFG_FILTER_WEIGHT = 1'b1;

    // input word kinds
    localparam logic CMD_SAMPLE    = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;

    // direction codes
    localparam logic [2:0] DIR_NEUTRAL = 3'd0;
    localparam logic [2:0] DIR_RIGHT   = 3'd1;
    localparam logic [2:0] DIR_LEFT    = 3'd2;
    localparam logic [2:0] DIR_UP      = 3'd3;
    localparam logic [2:0] DIR_DOWN    = 3'd4;

    typedef struct packed {
        logic signed [7:0] value_x;
        logic signed [7:0] value_y;
        logic signed [7:0] percent_x;
        logic signed [7:0] percent_y;
    } t_cond;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic       lowpass_on;
        logic [8:0] weight;
    } t_filt_cfg;

endpackage

`default_nettype wire

[rtl/joystick_axis_conditioner.sv]
// ----------------------------------------------------------------------------
// joystick_axis_conditioner
// dead zone, saturation, percent scaling, optional low-pass and direction
// ----------------------------------------------------------------------------
// takes one word per cycle while the queue is not full. a calibrate word stores the axis
// offsets and gives no result; a sample word passes the queue and then the output register,
// which loads when the output is free. the front stage conditions and scales the pair, a
// queue of QUEUE_DEPTH words decouples it from the back stage, whose filter memory updates
// with the output register, so one result per cycle is sustained while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_axis_conditioner #(
    parameter int DEAD_ZONE     = jac_pkg::DEAD_ZONE,
    parameter int DIR_THRESHOLD = jac_pkg::DIR_THRESHOLD,
    parameter int QUEUE_DEPTH   = jac_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // raw_x, raw_y
    input  wire logic        i_s_axis_tuser,   // cmd
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // value_x, value_y, percent_x, percent_y, direction
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [8:0]  i_cfg_data
);

    logic               r_lowpass_on;
    logic [8:0]         r_weight;
    logic               w_fire;
    logic               w_push;
    logic               w_pop;
    jac_pkg::t_cond     w_front_cond, w_q_cond, w_out_cond;
    jac_pkg::t_q_status w_q_status;
    jac_pkg::t_filt_cfg w_cfg;
    logic [2:0]         w_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowpass_on <= 1'b0;
            r_weight     <= jac_pkg::WEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jac_pkg::CFG_LOWPASS_ON:    r_lowpass_on <= i_cfg_data[0];
                jac_pkg::CFG_FILTER_WEIGHT: r_weight     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.lowpass_on = r_lowpass_on;
    assign w_cfg.weight     = r_weight;

    assign o_s_axis_tready = !w_q_status.full;
    assign w_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_push          = w_fire && i_s_axis_tuser == jac_pkg::CMD_SAMPLE;

    jac_front #(
        .DEAD_ZONE (DEAD_ZONE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_cmd   (i_s_axis_tuser),
        .i_raw_x (i_s_axis_tdata[7:0]),
        .i_raw_y (i_s_axis_tdata[15:8]),
        .o_cond  (w_front_cond)
    );

    jac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wdata  (w_front_cond),
        .i_pop    (w_pop),
        .o_rdata  (w_q_cond),
        .o_status (w_q_status)
    );

    jac_back #(
        .DIR_THRESHOLD (DIR_THRESHOLD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_status  (w_q_status),
        .i_cond      (w_q_cond),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_cond      (w_out_cond),
        .o_direction (w_dir)
    );

    assign o_m_axis_tdata = {5'b0, w_dir, w_out_cond.percent_y, w_out_cond.percent_x,
                             w_out_cond.value_y, w_out_cond.value_x};

`ifndef NO_ASSERTIONS
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue reports full and empty together");

    a_sample_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_q_status.empty && !o_m_axis_tvalid) |-> ##2 o_m_axis_tvalid)
        else $error("sample word did not reach the output");

    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[23:16]) >= -99 &&
                             $signed(o_m_axis_tdata[23:16]) <= 99 &&
                             $signed(o_m_axis_tdata[31:24]) >= -99 &&
                             $signed(o_m_axis_tdata[31:24]) <= 99))
        else $error("percent out of range");

    a_direction_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[34:32] <= jac_pkg::DIR_DOWN))
        else $error("direction code out of range");
`endif

endmodule

`default_nettype wire

[rtl/jac_front.sv]
// ----------------------------------------------------------------------------
// jac_front
// calibration offsets, dead zone, saturation and percent scaling
// ----------------------------------------------------------------------------
`default_nettype none

module jac_front #(
    parameter int DEAD_ZONE = jac_pkg::DEAD_ZONE
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic          i_cmd,
    input  wire logic [7:0]    i_raw_x,
    input  wire logic [7:0]    i_raw_y,
    output jac_pkg::t_cond     o_cond
);

    localparam logic signed [9:0] DZ = 10'(DEAD_ZONE);

    logic signed [7:0] r_off_x, r_off_y;
    logic signed [7:0] n_off_x, n_off_y;
    logic signed [7:0] w_vx, w_vy;

    function automatic logic signed [7:0] condition(input logic [7:0] raw,
                                                    input logic signed [7:0] off);
        logic signed [9:0] v;
        logic signed [7:0] r;
        v = $signed({2'b00, raw}) + 10'(off) - 10'sd127;
        if (v <= DZ && v >= -DZ) begin
            v = 10'sd0;
        end
        if (v > 10'sd127) begin
            r = 8'sd127;
        end else if (v < -10'sd127) begin
            r = -8'sd127;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic logic signed [7:0] to_percent(input logic signed [7:0] v);
        logic [6:0]  mag;
        logic [13:0] prod;
        logic [6:0]  q;
        mag  = v[7] ? 7'(-v) : v[6:0];
        prod = 14'(mag) * 14'd100;
        q    = prod[13:7];
        return v[7] ? 8'(-$signed({1'b0, q})) : $signed({1'b0, q});
    endfunction

    always_comb begin
        n_off_x = r_off_x;
        n_off_y = r_off_y;
        if (i_fire && i_cmd == jac_pkg::CMD_CALIBRATE) begin
            n_off_x = 8'(8'd127 - i_raw_x);
            n_off_y = 8'(8'd127 - i_raw_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
        end else begin
            r_off_x <= n_off_x;
            r_off_y <= n_off_y;
        end
    end

    assign w_vx = condition(i_raw_x, r_off_x);
    assign w_vy = condition(i_raw_y, r_off_y);

    assign o_cond.value_x   = w_vx;
    assign o_cond.value_y   = w_vy;
    assign o_cond.percent_x = to_percent(w_vx);
    assign o_cond.percent_y = to_percent(w_vy);

endmodule

`default_nettype wire

[rtl/jac_queue.sv]
// ----------------------------------------------------------------------------
// jac_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module jac_queue #(
    parameter int DEPTH = jac_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jac_pkg::t_cond i_wdata,
    input  wire logic          i_pop,
    output jac_pkg::t_cond     o_rdata,
    output jac_pkg::t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jac_pkg::t_cond r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata        = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

[rtl/jac_back.sv]
// ----------------------------------------------------------------------------
// jac_back
// low-pass filter, direction classification and output register
// ----------------------------------------------------------------------------
`default_nettype none

module jac_back #(
    parameter int DIR_THRESHOLD = jac_pkg::DIR_THRESHOLD
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jac_pkg::t_filt_cfg i_cfg,
    input  wire jac_pkg::t_q_status i_q_status,
    input  wire jac_pkg::t_cond     i_cond,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output jac_pkg::t_cond     o_cond,
    output logic [2:0]         o_direction
);

    localparam logic signed [7:0] TH = 8'(DIR_THRESHOLD);

    logic signed [7:0] r_filt_x, r_filt_y, n_filt_x, n_filt_y;
    logic              r_valid;
    jac_pkg::t_cond    r_cond, n_cond;
    logic [2:0]        r_dir, n_dir;
    logic [8:0]        w_new, w_old;

    function automatic logic signed [7:0] lowpass(input logic signed [7:0] p,
                                                  input logic signed [7:0] m,
                                                  input logic [8:0] wn,
                                                  input logic [8:0] wo);
        logic signed [18:0] pe, me, wne, woe, s;
        logic signed [10:0] q;
        pe  = 19'(p);
        me  = 19'(m);
        wne = $signed({10'b0, wn});
        woe = $signed({10'b0, wo});
        s   = pe * wne + me * woe;
        q   = s[18:8];
        if (s[18] && s[7:0] != 8'd0) begin
            q = 11'(q + 11'sd1);
        end
        return q[7:0];
    endfunction

    assign w_new = (i_cfg.weight > jac_pkg::ALPHA_ONE) ? jac_pkg::ALPHA_ONE : i_cfg.weight;
    assign w_old = 9'(jac_pkg::ALPHA_ONE - w_new);
    assign o_pop = !i_q_status.empty && (!r_valid || i_ready);

    always_comb begin
        n_cond   = i_cond;
        n_filt_x = r_filt_x;
        n_filt_y = r_filt_y;
        if (i_cfg.lowpass_on) begin
            n_filt_x         = lowpass(i_cond.percent_x, r_filt_x, w_new, w_old);
            n_filt_y         = lowpass(i_cond.percent_y, r_filt_y, w_new, w_old);
            n_cond.percent_x = n_filt_x;
            n_cond.percent_y = n_filt_y;
        end
        if (n_cond.percent_x > TH) begin
            n_dir = jac_pkg::DIR_RIGHT;
        end else if (n_cond.percent_x < -TH) begin
            n_dir = jac_pkg::DIR_LEFT;
        end else if (n_cond.percent_y > TH) begin
            n_dir = jac_pkg::DIR_UP;
        end else if (n_cond.percent_y < -TH) begin
            n_dir = jac_pkg::DIR_DOWN;
        end else begin
            n_dir = jac_pkg::DIR_NEUTRAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_filt_x <= '0;
            r_filt_y <= '0;
        end else begin
            if (o_pop) begin
                r_valid  <= 1'b1;
                r_filt_x <= n_filt_x;
                r_filt_y <= n_filt_y;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cond <= n_cond;
            r_dir  <= n_dir;
        end
    end

    assign o_valid     = r_valid;
    assign o_cond      = r_cond;
    assign o_direction = r_dir;

endmodule

`default_nettype wire
